### sv/blfp_pkg.sv
// shared types and constants for the binary log frame parser
// no dependencies; imported by every module of the block
`default_nettype none

package blfp_pkg;

  localparam logic [7:0] SYNC_ONE           = 8'hAA;
  localparam logic [7:0] SYNC_TWO           = 8'h44;
  localparam logic [7:0] SYNC_THREE         = 8'h12;
  localparam logic [7:0] FIXED_HEADER_BYTES = 8'd10;
  localparam logic [7:0] DEFAULT_HDR_LEN    = 8'd28;

  typedef enum logic [3:0] {
    PH_HUNT     = 4'd0,
    PH_SYNC1    = 4'd1,
    PH_SYNC2    = 4'd2,
    PH_HDR_LEN  = 4'd3,
    PH_ID_LO    = 4'd4,
    PH_ID_HI    = 4'd5,
    PH_TYPE     = 4'd6,
    PH_PORT     = 4'd7,
    PH_LEN_LO   = 4'd8,
    PH_LEN_HI   = 4'd9,
    PH_HDR_SKIP = 4'd10,
    PH_BODY     = 4'd11,
    PH_CRC0     = 4'd12,
    PH_CRC1     = 4'd13,
    PH_CRC2     = 4'd14,
    PH_CRC3     = 4'd15
  } phase_t;

  typedef struct packed {
    logic [7:0]  body_byte;
    logic [15:0] message_id;
    logic [15:0] body_index;
    logic [15:0] message_length;
    logic        last_of_body;
  } blfp_result_t;

endpackage

`default_nettype wire

### sv/blfp_framer.sv
// frame tracking state machine: sync hunt, header fields, body tagging, crc skip
// depends on blfp_pkg
`default_nettype none

module blfp_framer
  import blfp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         acc,
  input  wire logic [7:0]   rx_byte,
  output logic              res_valid,
  output blfp_result_t      res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  hdr_len_r, hdr_len_nxt;
  logic [15:0] msg_id_r, msg_id_nxt;
  logic [15:0] body_len_r, body_len_nxt;
  logic [7:0]  hdr_left_r, hdr_left_nxt;
  logic [15:0] body_cnt_r, body_cnt_nxt;

  logic [15:0] new_len;
  logic [7:0]  left_dec;
  logic        last;

  assign new_len  = {rx_byte, body_len_r[7:0]};
  assign left_dec = (hdr_left_r != 8'd0) ? hdr_left_r - 8'd1 : hdr_left_r;
  assign last     = ({1'b0, body_cnt_r} + 17'd1) >= {1'b0, body_len_r};

  always_comb begin
    phase_nxt    = phase_r;
    hdr_len_nxt  = hdr_len_r;
    msg_id_nxt   = msg_id_r;
    body_len_nxt = body_len_r;
    hdr_left_nxt = hdr_left_r;
    body_cnt_nxt = body_cnt_r;
    res_valid    = 1'b0;
    res.body_byte      = rx_byte;
    res.message_id     = msg_id_r;
    res.body_index     = body_cnt_r;
    res.message_length = body_len_r;
    res.last_of_body   = last;
    if (acc) begin
      case (phase_r)
        PH_HUNT: begin
          if (rx_byte == SYNC_ONE) phase_nxt = PH_SYNC1;
        end
        PH_SYNC1: begin
          if (rx_byte == SYNC_TWO) phase_nxt = PH_SYNC2;
          else if (rx_byte == SYNC_ONE) phase_nxt = PH_SYNC1;
          else phase_nxt = PH_HUNT;
        end
        PH_SYNC2: begin
          if (rx_byte == SYNC_THREE) phase_nxt = PH_HDR_LEN;
          else if (rx_byte == SYNC_ONE) phase_nxt = PH_SYNC1;
          else phase_nxt = PH_HUNT;
        end
        PH_HDR_LEN: begin
          hdr_len_nxt = rx_byte;
          phase_nxt   = PH_ID_LO;
        end
        PH_ID_LO: begin
          msg_id_nxt = {8'd0, rx_byte};
          phase_nxt  = PH_ID_HI;
        end
        PH_ID_HI: begin
          msg_id_nxt = {rx_byte, msg_id_r[7:0]};
          phase_nxt  = PH_TYPE;
        end
        PH_TYPE: phase_nxt = PH_PORT;
        PH_PORT: phase_nxt = PH_LEN_LO;
        PH_LEN_LO: begin
          body_len_nxt = {8'd0, rx_byte};
          phase_nxt    = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          body_len_nxt = new_len;
          body_cnt_nxt = 16'd0;
          if (hdr_len_r > FIXED_HEADER_BYTES) begin
            hdr_left_nxt = hdr_len_r - FIXED_HEADER_BYTES;
            phase_nxt    = PH_HDR_SKIP;
          end else begin
            hdr_left_nxt = 8'd0;
            phase_nxt    = (new_len != 16'd0) ? PH_BODY : PH_CRC0;
          end
        end
        PH_HDR_SKIP: begin
          hdr_left_nxt = left_dec;
          if (left_dec == 8'd0) phase_nxt = (body_len_r != 16'd0) ? PH_BODY : PH_CRC0;
        end
        PH_BODY: begin
          res_valid    = 1'b1;
          body_cnt_nxt = body_cnt_r + 16'd1;
          if (last) phase_nxt = PH_CRC0;
        end
        PH_CRC0: phase_nxt = PH_CRC1;
        PH_CRC1: phase_nxt = PH_CRC2;
        PH_CRC2: phase_nxt = PH_CRC3;
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      hdr_len_r  <= DEFAULT_HDR_LEN;
      msg_id_r   <= 16'd0;
      body_len_r <= 16'd0;
      hdr_left_r <= 8'd0;
      body_cnt_r <= 16'd0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_len_r  <= hdr_len_nxt;
      msg_id_r   <= msg_id_nxt;
      body_len_r <= body_len_nxt;
      hdr_left_r <= hdr_left_nxt;
      body_cnt_r <= body_cnt_nxt;
    end
  end

  // final body byte always hands over to the crc skip
  a_last_to_crc: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.last_of_body |=> phase_r == PH_CRC0)
    else $error("last body byte did not enter crc skip");

  // zero-length body with short header goes straight to crc skip
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    acc && phase_r == PH_LEN_HI && hdr_len_r <= FIXED_HEADER_BYTES && new_len == 16'd0
    |=> phase_r == PH_CRC0)
    else $error("zero-length body did not skip to crc");

  // body index advances by one for each emitted byte
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.last_of_body |=> body_cnt_r == $past(body_cnt_r) + 16'd1)
    else $error("body index did not advance");

endmodule

`default_nettype wire

### sv/blfp_out_buf.sv
// two-entry output buffer separating the framer from the result stream
// depends on blfp_pkg
`default_nettype none

module blfp_out_buf
  import blfp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire blfp_result_t push_data,
  output logic              space,
  output logic              head_valid,
  output blfp_result_t      head,
  input  wire logic         pop_ready
);

  blfp_result_t head_r, head_nxt;
  blfp_result_t tail_r, tail_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         pop;

  assign head_valid = cnt_r != 2'd0;
  assign head       = head_r;
  assign space      = cnt_r != 2'd2;
  assign pop        = head_valid && pop_ready;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          head_nxt = push_data;
          cnt_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_data;
        end else if (push) begin
          tail_nxt = push_data;
          cnt_nxt  = 2'd2;
        end else if (pop) begin
          cnt_nxt  = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt = tail_r;
          cnt_nxt  = 2'd1;
        end
      end
      default: cnt_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("buffer count out of range");

  // a full buffer never takes a request
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push)
    else $error("push into full buffer");

  // held head stays put while the consumer stalls
  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid && !pop_ready |=> head_valid && $stable(head_r))
    else $error("stalled head changed");

endmodule

`default_nettype wire

### sv/binary_log_frame_parser_unit.sv
// top level of the binary log frame parser: stream ports, framer and output buffer
// depends on blfp_pkg, blfp_framer, blfp_out_buf
`default_nettype none

// Takes one received byte per cycle, hunts for the sync sequence AA 44 12, reads the
// header length, message id and body length, and emits one request per body byte
// tagged with the message id, its index, the body length and a last flag; header
// padding and the four crc bytes are dropped unchecked. A byte is taken every cycle
// while the two-entry output buffer has room, and its result is registered in the buffer
// before it reaches the output. Input stalls whenever both buffer entries are held,
// even in a cycle in which the consumer takes one.
module binary_log_frame_parser_unit
  import blfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [7:0] body_byte, [23:8] body_index,
                                       // [39:24] message_length
  output logic [15:0]      out_tuser,  // [15:0] message_id
  output logic             out_tlast   // last_of_body
);

  logic         acc;
  logic         res_valid;
  blfp_result_t res;
  blfp_result_t head;
  logic         space;

  assign in_tready = space;
  assign acc       = in_tvalid && in_tready;

  blfp_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .rx_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  blfp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .space      (space),
    .head_valid (out_tvalid),
    .head       (head),
    .pop_ready  (out_tready)
  );

  assign out_tdata = {head.message_length, head.body_index, head.body_byte};
  assign out_tuser = head.message_id;
  assign out_tlast = head.last_of_body;

endmodule

`default_nettype wire

### tb/sv/blfp_body_checker.sv
`timescale 1ns / 100ps
// stream checker for binary_log_frame_parser_unit: follows the framing of accepted bytes,
// predicts every body request and compares it field by field with the output channel
// depends on blfp_pkg
module blfp_body_checker
  import blfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  input  wire logic [15:0] out_tuser,
  input  wire logic        out_tlast,
  output int               mismatches,
  output int               outstanding
);

  phase_t       trk_phase;
  logic [7:0]   trk_hdr_len;
  logic [15:0]  trk_id;
  logic [15:0]  trk_len;
  logic [7:0]   trk_skip_left;
  logic [15:0]  trk_count;
  blfp_result_t body_q[$];

  task track_byte(input logic [7:0] b);
    blfp_result_t req;
    logic         is_last;
    case (trk_phase)
      PH_HUNT: begin
        if (b == SYNC_ONE) trk_phase = PH_SYNC1;
      end
      PH_SYNC1: begin
        if (b == SYNC_TWO) trk_phase = PH_SYNC2;
        else if (b == SYNC_ONE) trk_phase = PH_SYNC1;
        else trk_phase = PH_HUNT;
      end
      PH_SYNC2: begin
        if (b == SYNC_THREE) trk_phase = PH_HDR_LEN;
        else if (b == SYNC_ONE) trk_phase = PH_SYNC1;
        else trk_phase = PH_HUNT;
      end
      PH_HDR_LEN: begin
        trk_hdr_len = b;
        trk_phase = PH_ID_LO;
      end
      PH_ID_LO: begin
        trk_id = {8'h00, b};
        trk_phase = PH_ID_HI;
      end
      PH_ID_HI: begin
        trk_id[15:8] = b;
        trk_phase = PH_TYPE;
      end
      PH_TYPE: trk_phase = PH_PORT;
      PH_PORT: trk_phase = PH_LEN_LO;
      PH_LEN_LO: begin
        trk_len = {8'h00, b};
        trk_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        trk_len[15:8] = b;
        trk_count = '0;
        if (trk_hdr_len > FIXED_HEADER_BYTES) begin
          trk_skip_left = trk_hdr_len - FIXED_HEADER_BYTES;
          trk_phase = PH_HDR_SKIP;
        end else begin
          // short header: body starts right away, or crc when the body is empty
          trk_skip_left = '0;
          trk_phase = (trk_len != 16'd0) ? PH_BODY : PH_CRC0;
        end
      end
      PH_HDR_SKIP: begin
        if (trk_skip_left != 8'd0) trk_skip_left = trk_skip_left - 8'd1;
        if (trk_skip_left == 8'd0) trk_phase = (trk_len != 16'd0) ? PH_BODY : PH_CRC0;
      end
      PH_BODY: begin
        is_last = ({1'b0, trk_count} + 17'd1) >= {1'b0, trk_len};
        req.body_byte      = b;
        req.message_id     = trk_id;
        req.body_index     = trk_count;
        req.message_length = trk_len;
        req.last_of_body   = is_last;
        body_q.insert(body_q.size(), req);
        trk_count = trk_count + 16'd1;
        if (is_last) trk_phase = PH_CRC0;
      end
      PH_CRC0: trk_phase = PH_CRC1;
      PH_CRC1: trk_phase = PH_CRC2;
      PH_CRC2: trk_phase = PH_CRC3;
      default: trk_phase = PH_HUNT;
    endcase
  endtask

  task report_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    blfp_result_t want;
    if (!rst_n) begin
      trk_phase     = PH_HUNT;
      trk_hdr_len   = DEFAULT_HDR_LEN;
      trk_id        = '0;
      trk_len       = '0;
      trk_skip_left = '0;
      trk_count     = '0;
      body_q.delete();
      mismatches    = 0;
    end else begin
      if (in_tvalid && in_tready) track_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (body_q.size() == 0) begin
          $display("%0t: unexpected request, expected none, actual byte %h id %h index %h",
                   $time, out_tdata[7:0], out_tuser, out_tdata[23:8]);
          mismatches++;
        end else begin
          want = body_q.pop_front();
          report_field("body_byte", 16'(want.body_byte), 16'(out_tdata[7:0]));
          report_field("message_id", want.message_id, out_tuser);
          report_field("body_index", want.body_index, out_tdata[23:8]);
          report_field("message_length", want.message_length, out_tdata[39:24]);
          report_field("last_of_body", 16'(want.last_of_body), 16'(out_tlast));
        end
      end
    end
    outstanding = body_q.size();
  end

endmodule

### tb/sv/binary_log_frame_parser_unit_tb.sv
`timescale 1ns / 100ps
// top of the frame parser testbench: clock, reset, byte stream stimulus, output back-pressure
// depends on blfp_pkg, binary_log_frame_parser_unit and blfp_body_checker
module binary_log_frame_parser_unit_tb
  import blfp_pkg::*;
();

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [15:0] out_tuser;
  logic        out_tlast;

  int mismatches;
  int outstanding;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_left      = 0;
  int sent_bytes     = 0;

  binary_log_frame_parser_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  blfp_body_checker CHK (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // consumer side: random stalls, or a long hold-off while hold_left runs down
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_bytes++;
  endtask

  // payload bytes lean toward the sync values to check that counted fields ignore them
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return SYNC_ONE;
      1:       return SYNC_TWO;
      2:       return SYNC_THREE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task send_sync();
    send_byte(SYNC_ONE);
    send_byte(SYNC_TWO);
    send_byte(SYNC_THREE);
  endtask

  // everything after the sync: header, padding, body and crc
  task send_header_body(input logic [7:0] hdr, input logic [15:0] id, input logic [15:0] len);
    int skip;
    skip = (hdr > FIXED_HEADER_BYTES) ? int'(hdr - FIXED_HEADER_BYTES) : 0;
    send_byte(hdr);
    send_byte(id[7:0]);
    send_byte(id[15:8]);
    send_byte(pick_byte());
    send_byte(pick_byte());
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    repeat (skip) send_byte(pick_byte());
    repeat (len) send_byte(pick_byte());
    repeat (4) send_byte(pick_byte());
  endtask

  task random_frame();
    logic [7:0]  hdr;
    logic [15:0] len;
    logic [7:0]  noise;
    case ($urandom_range(7))
      0: begin
        // junk between frames, never able to complete a sync
        repeat ($urandom_range(1, 4)) begin
          noise = 8'($urandom_range(255));
          if (noise == SYNC_THREE) noise = 8'h13;
          send_byte(noise);
        end
      end
      1: begin
        send_byte(SYNC_ONE);
        send_byte(SYNC_ONE);
      end
      2: begin
        send_byte(SYNC_ONE);
        send_byte(SYNC_TWO);
        send_byte(SYNC_ONE);
      end
      3: begin
        send_byte(SYNC_ONE);
        send_byte(SYNC_TWO);
      end
      4: begin
        send_byte(SYNC_ONE);
        send_byte(8'($urandom_range(0, 67)));
      end
      default: ;
    endcase
    hdr = ($urandom_range(9) < 8) ? 8'($urandom_range(14)) : 8'($urandom_range(15, 40));
    len = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 10));
    send_sync();
    send_header_body(hdr, 16'($urandom_range(65535)), len);
  endtask

  initial begin
    int start;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    out_tready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // repeated first sync byte and a sync byte in the third place, then a short header
    // with an empty body
    send_byte(SYNC_ONE);
    send_byte(SYNC_ONE);
    send_byte(SYNC_TWO);
    send_byte(SYNC_ONE);
    send_byte(SYNC_TWO);
    send_byte(SYNC_THREE);
    send_header_body(8'd0, 16'h0000, 16'h0000);
    // wrong second and third sync bytes drop back to hunting
    send_byte(SYNC_ONE);
    send_byte(8'h13);
    send_byte(SYNC_ONE);
    send_byte(SYNC_TWO);
    send_byte(8'h00);
    send_sync();
    send_header_body(8'd11, 16'hFFFF, 16'd2);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 61; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 61; end
        default: begin src_idle_pct = 34; sink_stall_pct = 34; end
      endcase
      start = sent_bytes;
      while (sent_bytes - start < 80) random_frame();
      if (ph == 0) begin
        // consumer holds off long enough for the output buffer to fill and the input to stall
        hold_left = 400;
        send_sync();
        send_header_body(8'd10, 16'($urandom_range(65535)), 16'd40);
      end
    end
    in_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
sv/blfp_pkg.sv
sv/blfp_framer.sv
sv/blfp_out_buf.sv
sv/binary_log_frame_parser_unit.sv
tb/sv/blfp_body_checker.sv
tb/sv/binary_log_frame_parser_unit_tb.sv
